[rtl/tcs_pkg.sv]
// tcs_pkg: telnet byte codes and the result burst type for the command stripper
// used by tcs_parse and telnet_command_stripper_top, no dependencies
`default_nettype none
package tcs_pkg;

	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_SE   = 8'd240;
	localparam logic [7:0] TELOPT_ECHO = 8'd1;
	localparam logic [7:0] TELOPT_SGA  = 8'd3;

	localparam int unsigned MAX_RES = 7;

	// results caused by one received byte, entry 0 goes out first
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [MAX_RES-1:0]      tc;
		logic [2:0]              cnt;
	} burst_t;

endpackage
`default_nettype wire

[rtl/telnet_command_stripper_top.sv]
// telnet_command_stripper_top: splits telnet bytes into shell data and negotiation replies
// depends on tcs_pkg and tcs_parse
//
//  channel  handshake               payload
//  rx       in_valid / in_ready     rx_byte[7:0]
//  result   out_valid / out_ready   out_byte[7:0], to_client, last
//
// a byte is parsed in the cycle it is accepted and its results land in a burst register
// results leave one per cycle while out_ready is high, from the head of that register, shifting down
// rx is held off while more than one result of a burst is still waiting
// in_ready is high while the burst register is empty or its final result is being taken
// reset clears the parse state and the offer flag, as at session start
`default_nettype none
module telnet_command_stripper_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            to_client,
	output logic            last
);
	import tcs_pkg::*;

	burst_t                  burst;
	logic [MAX_RES-1:0][7:0] bytes_q;
	logic [MAX_RES-1:0]      tc_q;
	logic [2:0]              rem_q;
	logic                    in_take;
	logic                    out_take;

	assign out_valid = (rem_q != 3'd0);
	assign out_take  = out_valid && out_ready;
	assign in_ready  = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ready);
	assign in_take   = in_valid && in_ready;
	assign out_byte  = bytes_q[0];
	assign to_client = tc_q[0];
	assign last      = (rem_q == 3'd1);

	tcs_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (in_take),
		.rx_byte (rx_byte),
		.burst   (burst)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (in_take) begin
			rem_q <= burst.cnt;
		end else if (out_take) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			bytes_q <= burst.bytes;
			tc_q    <= burst.tc;
		end else if (out_take) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
				tc_q[i]    <= tc_q[i+1];
			end
		end
	end

	a_hold_rx: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q > 3'd1 |-> !in_ready)
		else $error("rx accepted while a burst is still pending");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !in_take |=> rem_q == 3'($past(rem_q) - 3'd1))
		else $error("burst count did not step down on a taken result");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && burst.cnt == 3'd0 |=> !out_valid)
		else $error("result shown for a byte that gives none");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> rem_q == $past(burst.cnt))
		else $error("burst count not loaded on an rx transaction");

endmodule
`default_nettype wire

[rtl/tcs_parse.sv]
// tcs_parse: telnet parse state and the burst of results for one received byte
// depends on tcs_pkg
`default_nettype none
module tcs_parse (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    rx_byte,
	output tcs_pkg::burst_t    burst
);
	import tcs_pkg::*;

	localparam logic [2:0] PH_DATA   = 3'd0;
	localparam logic [2:0] PH_IAC    = 3'd1;
	localparam logic [2:0] PH_VERB   = 3'd2;
	localparam logic [2:0] PH_SUB    = 3'd3;
	localparam logic [2:0] PH_SUBIAC = 3'd4;

	logic [2:0] phase_q, phase_d;
	logic [7:0] verb_q, verb_d;
	logic       seen_q, seen_d;
	logic       offer;
	logic [7:0] reply;

	always_comb begin
		phase_d = phase_q;
		verb_d  = verb_q;
		seen_d  = seen_q;
		burst   = '0;
		offer   = 1'b0;
		reply   = 8'd0;
		case (phase_q)
			PH_IAC: begin
				offer = !seen_q;
				seen_d = 1'b1;
				if (offer) begin
					burst.bytes[0] = B_IAC;
					burst.bytes[1] = B_WILL;
					burst.bytes[2] = TELOPT_ECHO;
					burst.bytes[3] = B_IAC;
					burst.bytes[4] = B_WILL;
					burst.bytes[5] = TELOPT_SGA;
					burst.tc[5:0]  = '1;
					burst.cnt      = 3'd6;
				end
				if (rx_byte == B_IAC) begin
					// escaped 255 is data, it follows the offer if one goes out
					if (offer) begin
						burst.bytes[6] = B_IAC;
						burst.cnt      = 3'd7;
					end else begin
						burst.bytes[0] = B_IAC;
						burst.cnt      = 3'd1;
					end
					phase_d = PH_DATA;
				end else if (rx_byte == B_SB) begin
					phase_d = PH_SUB;
				end else if (rx_byte inside {B_DO, B_DONT, B_WILL, B_WONT}) begin
					verb_d  = rx_byte;
					phase_d = PH_VERB;
				end else begin
					phase_d = PH_DATA;
				end
			end
			PH_VERB: begin
				if (verb_q == B_DO)
					reply = (rx_byte == TELOPT_ECHO || rx_byte == TELOPT_SGA) ? B_WILL : B_WONT;
				else if (verb_q == B_WILL)
					reply = B_DONT;
				if (reply != 8'd0) begin
					burst.bytes[0] = B_IAC;
					burst.bytes[1] = reply;
					burst.bytes[2] = rx_byte;
					burst.tc[2:0]  = '1;
					burst.cnt      = 3'd3;
				end
				phase_d = PH_DATA;
			end
			PH_SUB: begin
				if (rx_byte == B_IAC)
					phase_d = PH_SUBIAC;
			end
			PH_SUBIAC: begin
				phase_d = (rx_byte == B_SE) ? PH_DATA : PH_SUB;
			end
			default: begin
				// the plain data phase; unreachable codes behave as plain data too
				if (rx_byte == B_IAC) begin
					phase_d = PH_IAC;
				end else begin
					phase_d = PH_DATA;
					burst.bytes[0] = rx_byte;
					burst.cnt      = 3'd1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
			verb_q  <= 8'd0;
			seen_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			verb_q  <= verb_d;
			seen_q  <= seen_d;
		end
	end

	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |=> seen_q)
		else $error("offer flag cleared outside reset");

	a_offer_once: assert property (@(posedge clk) disable iff (!arst_n)
		take && offer |=> seen_q)
		else $error("offer sent without setting the flag");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_SUB && rx_byte != B_IAC |=> phase_q == PH_SUB)
		else $error("subnegotiation left without IAC");

endmodule
`default_nettype wire
